[rtl/core/tcc_pkg.sv]
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared constants, types and codes of the touch coordinate conversion unit.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int SAMPLES    = 4;
  localparam int FULL_SCALE = 4095;
  localparam int SLOTS      = 8;

  localparam int X_MAX = 320;
  localparam int Y_MAX = 280;

  localparam int BYTE_W   = 8;
  localparam int HI_SHIFT = 5;
  localparam int LO_SHIFT = 3;
  localparam int RAW_W    = BYTE_W + HI_SHIFT;

  localparam int SUM_W   = 17;
  localparam int CNT_W   = 4;
  localparam int SLOT_W  = 3;
  localparam int COORD_W = SUM_W + 2;
  localparam int COEF_W  = 32;
  localparam int PROD_W  = COORD_W + COEF_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int SCR_W   = 9;
  localparam int DCNT_W  = $clog2(ACC_W);
  localparam int REM_W   = COEF_W + 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ROT_NONE = 2'd0,
    ROT_BOTH = 2'd1,
    ROT_Y    = 2'd2,
    ROT_X    = 2'd3
  } rot_t;

  typedef enum logic [2:0] {
    REG_ROT = 3'd0,
    REG_A   = 3'd1,
    REG_B   = 3'd2,
    REG_C   = 3'd3,
    REG_D   = 3'd4,
    REG_E   = 3'd5,
    REG_F   = 3'd6,
    REG_DEN = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MS_AX_A = 3'd0,
    MS_AY_B = 3'd1,
    MS_AX_D = 3'd2,
    MS_AY_E = 3'd3,
    MS_LAST = 3'd4
  } mul_step_t;

  typedef enum logic [2:0] {
    BK_IDLE = 3'd0,
    BK_MUL  = 3'd1,
    BK_STX  = 3'd2,
    BK_WTX  = 3'd3,
    BK_STY  = 3'd4,
    BK_WTY  = 3'd5,
    BK_OUT  = 3'd6
  } back_state_t;

  typedef struct packed {
    rot_t                     rotation_mode;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic signed [COEF_W-1:0] coef_d;
    logic signed [COEF_W-1:0] coef_e;
    logic signed [COEF_W-1:0] coef_f;
    logic signed [COEF_W-1:0] coef_den;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic [SLOT_W-1:0]         slot;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/core/tcc_in_if.sv]
// ----------------------------------------------------------------------------
// tcc_in_if
// Input channel: one sample pair of returned bytes and a slot per item.
// ----------------------------------------------------------------------------
interface tcc_in_if;
  logic                         valid;
  logic                         ready;
  logic [tcc_pkg::BYTE_W-1:0]   x_high_byte;
  logic [tcc_pkg::BYTE_W-1:0]   x_low_byte;
  logic [tcc_pkg::BYTE_W-1:0]   y_high_byte;
  logic [tcc_pkg::BYTE_W-1:0]   y_low_byte;
  logic [tcc_pkg::SLOT_W-1:0]   slot_index;

  modport source (
    output valid, x_high_byte, x_low_byte, y_high_byte, y_low_byte, slot_index,
    input  ready
  );
  modport sink (
    input  valid, x_high_byte, x_low_byte, y_high_byte, y_low_byte, slot_index,
    output ready
  );
endinterface

[rtl/core/tcc_out_if.sv]
// ----------------------------------------------------------------------------
// tcc_out_if
// Result channel: calibrated screen coordinate and slot per item.
// ----------------------------------------------------------------------------
interface tcc_out_if;
  logic                        valid;
  logic                        ready;
  logic [tcc_pkg::SCR_W-1:0]   screen_x;
  logic [tcc_pkg::SCR_W-1:0]   screen_y;
  logic [tcc_pkg::SLOT_W-1:0]  slot_out;

  modport source (
    output valid, screen_x, screen_y, slot_out,
    input  ready
  );
  modport sink (
    input  valid, screen_x, screen_y, slot_out,
    output ready
  );
endinterface

[rtl/core/tcc_front.sv]
// ----------------------------------------------------------------------------
// tcc_front
// Accepts sample pairs, sums a group, averages and mirrors on the last pair.
// ----------------------------------------------------------------------------
module tcc_front (
  input  logic                clk,
  input  logic                rst_n,
  tcc_in_if.sink              in_if,
  input  tcc_pkg::rot_t       rotation_mode,
  input  tcc_pkg::q_stat_t    q_stat,
  output logic                push,
  output tcc_pkg::job_t       job
);

  logic [tcc_pkg::SUM_W-1:0]   sum_x_r, sum_x_nxt;
  logic [tcc_pkg::SUM_W-1:0]   sum_y_r, sum_y_nxt;
  logic [tcc_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;

  logic [tcc_pkg::RAW_W-1:0]   raw_x, raw_y;
  logic [tcc_pkg::SUM_W-1:0]   add_x, add_y;
  logic [tcc_pkg::SUM_W-1:0]   avg_x, avg_y;
  logic signed [tcc_pkg::COORD_W-1:0] ext_x, ext_y, fs;
  logic                        accept, last;

  assign in_if.ready = !q_stat.full;
  assign accept      = in_if.valid && in_if.ready;
  assign last        = (cnt_r == tcc_pkg::CNT_W'(tcc_pkg::SAMPLES - 1));
  assign push        = accept && last;

  assign raw_x = tcc_pkg::RAW_W'({in_if.x_high_byte, tcc_pkg::HI_SHIFT'(0)})
               | tcc_pkg::RAW_W'(in_if.x_low_byte >> tcc_pkg::LO_SHIFT);
  assign raw_y = tcc_pkg::RAW_W'({in_if.y_high_byte, tcc_pkg::HI_SHIFT'(0)})
               | tcc_pkg::RAW_W'(in_if.y_low_byte >> tcc_pkg::LO_SHIFT);

  assign add_x = sum_x_r + tcc_pkg::SUM_W'(raw_x);
  assign add_y = sum_y_r + tcc_pkg::SUM_W'(raw_y);

  assign avg_x = tcc_pkg::SUM_W'(add_x / tcc_pkg::SAMPLES);
  assign avg_y = tcc_pkg::SUM_W'(add_y / tcc_pkg::SAMPLES);
  assign ext_x = $signed({2'b00, avg_x});
  assign ext_y = $signed({2'b00, avg_y});
  assign fs    = tcc_pkg::COORD_W'(tcc_pkg::FULL_SCALE);

  always_comb begin
    job.ax   = ext_x;
    job.ay   = ext_y;
    job.slot = tcc_pkg::SLOT_W'(in_if.slot_index % tcc_pkg::SLOTS);
    case (rotation_mode)
      tcc_pkg::ROT_BOTH: begin
        job.ax = fs - ext_x;
        job.ay = fs - ext_y;
      end
      tcc_pkg::ROT_Y: begin
        job.ay = fs - ext_y;
      end
      tcc_pkg::ROT_X: begin
        job.ax = fs - ext_x;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    cnt_nxt   = cnt_r;
    if (accept) begin
      if (last) begin
        sum_x_nxt = '0;
        sum_y_nxt = '0;
        cnt_nxt   = '0;
      end else begin
        sum_x_nxt = add_x;
        sum_y_nxt = add_y;
        cnt_nxt   = cnt_r + tcc_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      cnt_r   <= '0;
    end else begin
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[rtl/core/tcc_fifo.sv]
// ----------------------------------------------------------------------------
// tcc_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module tcc_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tcc_pkg::job_t     push_job,
  input  logic              pop,
  output tcc_pkg::job_t     head,
  output tcc_pkg::q_stat_t  q_stat
);

  tcc_pkg::job_t              mem_r [tcc_pkg::QDEPTH];
  logic [tcc_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [tcc_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [tcc_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       do_push, do_pop;

  assign q_stat.full  = (cnt_r == tcc_pkg::QCNT_W'(tcc_pkg::QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == tcc_pkg::QPTR_W'(tcc_pkg::QDEPTH - 1)) ? '0
                 : wr_ptr_r + tcc_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == tcc_pkg::QPTR_W'(tcc_pkg::QDEPTH - 1)) ? '0
                 : rd_ptr_r + tcc_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + tcc_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - tcc_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[rtl/core/tcc_div.sv]
// ----------------------------------------------------------------------------
// tcc_div
// Signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module tcc_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [tcc_pkg::ACC_W-1:0]   num,
  input  logic signed [tcc_pkg::COEF_W-1:0]  den,
  output logic                               done,
  output logic signed [tcc_pkg::ACC_W-1:0]   quot
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [tcc_pkg::DCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [tcc_pkg::REM_W-1:0]   rem_r, rem_nxt;
  logic [tcc_pkg::ACC_W-1:0]   q_r, q_nxt;
  logic [tcc_pkg::COEF_W-1:0]  dmag_r, dmag_nxt;
  logic                        neg_r, neg_nxt;

  logic [tcc_pkg::REM_W-1:0]   rem_sh;
  logic                        ge;

  assign rem_sh = {rem_r[tcc_pkg::REM_W-2:0], q_r[tcc_pkg::ACC_W-1]};
  assign ge     = (rem_sh >= {1'b0, dmag_r});
  assign done   = done_r;
  assign quot   = neg_r ? -$signed(q_r) : $signed(q_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dmag_nxt = dmag_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = tcc_pkg::DCNT_W'(tcc_pkg::ACC_W - 1);
      rem_nxt  = '0;
      q_nxt    = num[tcc_pkg::ACC_W-1] ? tcc_pkg::ACC_W'(-num) : tcc_pkg::ACC_W'(num);
      dmag_nxt = den[tcc_pkg::COEF_W-1] ? tcc_pkg::COEF_W'(-den) : tcc_pkg::COEF_W'(den);
      neg_nxt  = num[tcc_pkg::ACC_W-1] ^ den[tcc_pkg::COEF_W-1];
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_sh - {1'b0, dmag_r}) : rem_sh;
      q_nxt   = {q_r[tcc_pkg::ACC_W-2:0], ge};
      cnt_nxt = cnt_r - tcc_pkg::DCNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    dmag_r <= dmag_nxt;
    neg_r  <= neg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

[rtl/core/tcc_back.sv]
// ----------------------------------------------------------------------------
// tcc_back
// Takes queued jobs, applies the affine calibration, clamps, holds the result.
// ----------------------------------------------------------------------------
module tcc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  tcc_pkg::cfg_t     cfg,
  input  tcc_pkg::q_stat_t  q_stat,
  input  tcc_pkg::job_t     head,
  output logic              pop,
  tcc_out_if.source         out_if
);

  tcc_pkg::back_state_t state_r, state_nxt;
  tcc_pkg::mul_step_t   step_r, step_nxt;
  tcc_pkg::job_t        job_r, job_nxt;

  logic signed [tcc_pkg::PROD_W-1:0]  prod_r, prod_nxt, prod_mul;
  logic signed [tcc_pkg::ACC_W-1:0]   acc_x_r, acc_x_nxt;
  logic signed [tcc_pkg::ACC_W-1:0]   acc_y_r, acc_y_nxt;
  logic [tcc_pkg::SCR_W-1:0]          res_x_r, res_x_nxt;
  logic [tcc_pkg::SCR_W-1:0]          res_y_r, res_y_nxt;

  logic signed [tcc_pkg::COORD_W-1:0] mul_a;
  logic signed [tcc_pkg::COEF_W-1:0]  mul_b;
  logic signed [tcc_pkg::ACC_W-1:0]   div_num, div_quot;
  logic                               div_start, div_done;

  function automatic logic [tcc_pkg::SCR_W-1:0] clamp_to(
    input logic signed [tcc_pkg::ACC_W-1:0] v,
    input int                               hi
  );
    logic [tcc_pkg::SCR_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > tcc_pkg::ACC_W'(hi)) begin
      r = tcc_pkg::SCR_W'(hi);
    end else begin
      r = v[tcc_pkg::SCR_W-1:0];
    end
    return r;
  endfunction

  tcc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (cfg.coef_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    case (step_r)
      tcc_pkg::MS_AY_B: begin
        mul_a = job_r.ay;
        mul_b = cfg.coef_b;
      end
      tcc_pkg::MS_AX_D: begin
        mul_a = job_r.ax;
        mul_b = cfg.coef_d;
      end
      tcc_pkg::MS_AY_E: begin
        mul_a = job_r.ay;
        mul_b = cfg.coef_e;
      end
      default: begin
        mul_a = job_r.ax;
        mul_b = cfg.coef_a;
      end
    endcase
  end

  assign prod_mul = tcc_pkg::PROD_W'(mul_a) * tcc_pkg::PROD_W'(mul_b);
  assign div_num  = (state_r == tcc_pkg::BK_STY) ? acc_y_r : acc_x_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcc_pkg::BK_IDLE: begin
        if (!q_stat.empty) state_nxt = tcc_pkg::BK_MUL;
      end
      tcc_pkg::BK_MUL: begin
        if (step_r == tcc_pkg::MS_LAST) begin
          state_nxt = (cfg.coef_den == '0) ? tcc_pkg::BK_OUT : tcc_pkg::BK_STX;
        end
      end
      tcc_pkg::BK_STX: state_nxt = tcc_pkg::BK_WTX;
      tcc_pkg::BK_WTX: begin
        if (div_done) state_nxt = tcc_pkg::BK_STY;
      end
      tcc_pkg::BK_STY: state_nxt = tcc_pkg::BK_WTY;
      tcc_pkg::BK_WTY: begin
        if (div_done) state_nxt = tcc_pkg::BK_OUT;
      end
      tcc_pkg::BK_OUT: begin
        if (out_if.ready) state_nxt = tcc_pkg::BK_IDLE;
      end
      default: state_nxt = tcc_pkg::BK_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    pop       = 1'b0;
    div_start = 1'b0;
    job_nxt   = job_r;
    step_nxt  = step_r;
    prod_nxt  = prod_r;
    acc_x_nxt = acc_x_r;
    acc_y_nxt = acc_y_r;
    res_x_nxt = res_x_r;
    res_y_nxt = res_y_r;
    case (state_r)
      tcc_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          pop      = 1'b1;
          job_nxt  = head;
          step_nxt = tcc_pkg::MS_AX_A;
        end
      end
      tcc_pkg::BK_MUL: begin
        step_nxt = tcc_pkg::mul_step_t'(step_r + 3'd1);
        case (step_r)
          tcc_pkg::MS_AX_A: begin
            prod_nxt = prod_mul;
          end
          tcc_pkg::MS_AY_B: begin
            acc_x_nxt = tcc_pkg::ACC_W'(cfg.coef_c) + tcc_pkg::ACC_W'(prod_r);
            prod_nxt  = prod_mul;
          end
          tcc_pkg::MS_AX_D: begin
            acc_x_nxt = acc_x_r + tcc_pkg::ACC_W'(prod_r);
            prod_nxt  = prod_mul;
          end
          tcc_pkg::MS_AY_E: begin
            acc_y_nxt = tcc_pkg::ACC_W'(cfg.coef_f) + tcc_pkg::ACC_W'(prod_r);
            prod_nxt  = prod_mul;
          end
          default: begin
            acc_y_nxt = acc_y_r + tcc_pkg::ACC_W'(prod_r);
            res_x_nxt = '0;
            res_y_nxt = '0;
            step_nxt  = tcc_pkg::MS_AX_A;
          end
        endcase
      end
      tcc_pkg::BK_STX, tcc_pkg::BK_STY: begin
        div_start = 1'b1;
      end
      tcc_pkg::BK_WTX: begin
        if (div_done) res_x_nxt = clamp_to(div_quot, tcc_pkg::X_MAX);
      end
      tcc_pkg::BK_WTY: begin
        if (div_done) res_y_nxt = clamp_to(div_quot, tcc_pkg::Y_MAX);
      end
      default: begin
      end
    endcase
  end

  assign out_if.valid    = (state_r == tcc_pkg::BK_OUT);
  assign out_if.screen_x = res_x_r;
  assign out_if.screen_y = res_y_r;
  assign out_if.slot_out = job_r.slot;

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    prod_r  <= prod_nxt;
    acc_x_r <= acc_x_nxt;
    acc_y_r <= acc_y_nxt;
    res_x_r <= res_x_nxt;
    res_y_r <= res_y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcc_pkg::BK_IDLE;
      step_r  <= tcc_pkg::MS_AX_A;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

[rtl/core/touch_coordinate_conversion_unit.sv]
// ----------------------------------------------------------------------------
// touch_coordinate_conversion_unit
// Averages groups of touch sample pairs and maps them to screen coordinates.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-------------------------------------
//   in_if    | in  | valid / ready      | x/y high and low bytes, slot_index
//   out_if   | out | valid / ready      | screen_x, screen_y, slot_out
//   cfg_*    | in  | cfg_we, no wait    | cfg_index, cfg_wdata
//
// an item is taken while the two-entry job queue has room.
// per group of SAMPLES items the back pops the job, runs 5 multiply steps, makes
// two divider passes (start, quotient bits, done) and then presents the result.
// a zero divisor skips the divider and gives a zero result.
// reset loads the default coefficients, clears the sums and empties the queue.
// a stalled result holds the back; the front keeps taking items until full.
// ----------------------------------------------------------------------------
module touch_coordinate_conversion_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  tcc_in_if.sink                       in_if,
  tcc_out_if.source                    out_if,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [tcc_pkg::COEF_W-1:0]   cfg_wdata
);

  tcc_pkg::cfg_t    cfg_r, cfg_nxt;
  tcc_pkg::job_t    push_job, head;
  tcc_pkg::q_stat_t q_stat;
  logic             push, pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (tcc_pkg::cfg_idx_t'(cfg_index))
        tcc_pkg::REG_ROT: cfg_nxt.rotation_mode = tcc_pkg::rot_t'(cfg_wdata[1:0]);
        tcc_pkg::REG_A:   cfg_nxt.coef_a        = cfg_wdata;
        tcc_pkg::REG_B:   cfg_nxt.coef_b        = cfg_wdata;
        tcc_pkg::REG_C:   cfg_nxt.coef_c        = cfg_wdata;
        tcc_pkg::REG_D:   cfg_nxt.coef_d        = cfg_wdata;
        tcc_pkg::REG_E:   cfg_nxt.coef_e        = cfg_wdata;
        tcc_pkg::REG_F:   cfg_nxt.coef_f        = cfg_wdata;
        tcc_pkg::REG_DEN: cfg_nxt.coef_den      = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rotation_mode <= tcc_pkg::ROT_NONE;
      cfg_r.coef_a        <= tcc_pkg::COEF_W'(1);
      cfg_r.coef_b        <= '0;
      cfg_r.coef_c        <= '0;
      cfg_r.coef_d        <= '0;
      cfg_r.coef_e        <= tcc_pkg::COEF_W'(1);
      cfg_r.coef_f        <= '0;
      cfg_r.coef_den      <= tcc_pkg::COEF_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tcc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_if         (in_if),
    .rotation_mode (cfg_r.rotation_mode),
    .q_stat        (q_stat),
    .push          (push),
    .job           (push_job)
  );

  tcc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  tcc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_stat (q_stat),
    .head   (head),
    .pop    (pop),
    .out_if (out_if)
  );

endmodule
